// ===== hw/rtl/iirdf_pkg.sv =====
// constants shared by the direct-form-i iir filter core and its datapath
// no dependencies
`default_nettype none

package iirdf_pkg;

  localparam int COEF_WIDTH    = 16;
  localparam int NUM_TAPS      = 4;
  localparam int TAP_IDX_WIDTH = 2;
  localparam int IN_DEPTH      = 3;
  localparam int OUT_DEPTH     = 4;

  localparam int PADDR_WIDTH   = 5;
  localparam int PDATA_WIDTH   = 32;
  localparam int REG_IDX_WIDTH = 3;

  // register map, byte address 4*index
  localparam logic [REG_IDX_WIDTH-1:0] REG_FF_COEF_0 = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FB_COEF_0 = 3'd4;

  localparam logic signed [COEF_WIDTH-1:0] FF_COEF_0_RESET = 16'sd16384;

  typedef logic signed [COEF_WIDTH-1:0] coef_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iirdf_mac.sv =====
// multiply-accumulate, rounding and saturation for one output sample
// depends on iirdf_pkg
`default_nettype none

module iirdf_mac #(
  parameter int FF_TAPS        = 4,
  parameter int FB_TAPS        = 4,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic signed [SAMPLE_WIDTH-1:0] x,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_hist [iirdf_pkg::IN_DEPTH],
  input  wire logic signed [SAMPLE_WIDTH-1:0] y_hist [iirdf_pkg::OUT_DEPTH],
  input  wire iirdf_pkg::coef_t               ff_coef [iirdf_pkg::NUM_TAPS],
  input  wire iirdf_pkg::coef_t               fb_coef [iirdf_pkg::NUM_TAPS],
  output logic signed [SAMPLE_WIDTH-1:0]      y,
  output logic                                sat
);
  import iirdf_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + 4;
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  logic signed [PROD_W-1:0] ff_prod [NUM_TAPS];
  logic signed [PROD_W-1:0] fb_prod [NUM_TAPS];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  scaled;

  // eight parallel products, unused taps forced to zero
  always_comb begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (i >= FF_TAPS) begin
        ff_prod[i] = '0;
      end else if (i == 0) begin
        ff_prod[i] = PROD_W'(ff_coef[i]) * PROD_W'(x);
      end else begin
        ff_prod[i] = PROD_W'(ff_coef[i]) * PROD_W'(x_hist[i-1]);
      end
      if (i >= FB_TAPS) begin
        fb_prod[i] = '0;
      end else begin
        fb_prod[i] = PROD_W'(fb_coef[i]) * PROD_W'(y_hist[i]);
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      acc = acc + ACC_W'(ff_prod[i]) + ACC_W'(fb_prod[i]);
    end
  end

  // round half up, then floor by arithmetic shift
  assign scaled = (acc + HALF) >>> COEF_FRAC_BITS;

  always_comb begin
    if (scaled > MAXV) begin
      y   = MAXV[SAMPLE_WIDTH-1:0];
      sat = 1'b1;
    end else if (scaled < MINV) begin
      y   = MINV[SAMPLE_WIDTH-1:0];
      sat = 1'b1;
    end else begin
      y   = scaled[SAMPLE_WIDTH-1:0];
      sat = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iir_direct_form_filter_core.sv =====
// Direct-form-I IIR filter, four feedforward and four feedback taps (feedback added),
// Q2.14 coefficients over an APB-style register port. One sample is taken per clock
// cycle while the result register is not stalled; each sample passes the input
// register, then the result register. The feedback path - eight products, the adder
// tree, rounding and saturation into the output history - is combinational and sets
// the clock rate. Coefficient writes must be made while the filter is idle.
// top level; depends on iirdf_pkg and iirdf_mac
`default_nettype none

module iir_direct_form_filter_core #(
  parameter int FF_TAPS        = 4,
  parameter int FB_TAPS        = 4,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [iirdf_pkg::PADDR_WIDTH-1:0]     paddr,
  input  wire logic [iirdf_pkg::PDATA_WIDTH-1:0]     pwdata,
  output logic [iirdf_pkg::PDATA_WIDTH-1:0]          prdata,
  output logic                                       pready,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        sample_in,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]             sample_out,
  output logic                                       saturated
);
  import iirdf_pkg::*;

  coef_t ff_coef [NUM_TAPS];
  coef_t fb_coef [NUM_TAPS];

  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic                           x_valid;
  logic signed [SAMPLE_WIDTH-1:0] x_hist [IN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] y_hist [OUT_DEPTH];

  logic signed [SAMPLE_WIDTH-1:0] y_next;
  logic                           sat_next;
  logic                           advance;
  logic                           cfg_write;
  logic [REG_IDX_WIDTH-1:0]       reg_idx;
  logic [TAP_IDX_WIDTH-1:0]       tap_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[PADDR_WIDTH-1:2];
  assign tap_idx   = reg_idx[TAP_IDX_WIDTH-1:0];

  always_comb begin
    if (reg_idx < REG_FB_COEF_0) begin
      prdata = PDATA_WIDTH'(ff_coef[tap_idx]);
    end else begin
      prdata = PDATA_WIDTH'(fb_coef[tap_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        ff_coef[i] <= '0;
        fb_coef[i] <= '0;
      end
      ff_coef[REG_FF_COEF_0[TAP_IDX_WIDTH-1:0]] <= FF_COEF_0_RESET;
    end else if (cfg_write) begin
      if (reg_idx < REG_FB_COEF_0) begin
        ff_coef[tap_idx] <= pwdata[COEF_WIDTH-1:0];
      end else begin
        fb_coef[tap_idx] <= pwdata[COEF_WIDTH-1:0];
      end
    end
  end

  // the held sample moves on whenever the result register is free or draining
  assign advance  = x_valid && (!out_valid || out_ready);
  assign in_ready = !x_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else if (in_ready) begin
      x_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_reg <= sample_in;
    end
  end

  iirdf_mac #(
    .FF_TAPS        (FF_TAPS),
    .FB_TAPS        (FB_TAPS),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .x       (x_reg),
    .x_hist  (x_hist),
    .y_hist  (y_hist),
    .ff_coef (ff_coef),
    .fb_coef (fb_coef),
    .y       (y_next),
    .sat     (sat_next)
  );

  // histories shift in full on every sample, whatever the tap counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IN_DEPTH; i++) begin
        x_hist[i] <= '0;
      end
      for (int i = 0; i < OUT_DEPTH; i++) begin
        y_hist[i] <= '0;
      end
    end else if (advance) begin
      x_hist[0] <= x_reg;
      for (int i = 1; i < IN_DEPTH; i++) begin
        x_hist[i] <= x_hist[i-1];
      end
      y_hist[0] <= y_next;
      for (int i = 1; i < OUT_DEPTH; i++) begin
        y_hist[i] <= y_hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out <= y_next;
      saturated  <= sat_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iirdf_checker.sv =====
// port-level checks for the iir filter core, attached by bind
// depends on iir_direct_form_filter_core
`default_nettype none

module iirdf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [SAMPLE_WIDTH-1:0] sample_out,
  input wire logic                           saturated
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
    else $error("result beat changed while stalled");

  // a clipped result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> sample_out == SMAX || sample_out == SMIN)
    else $error("saturated flag without rail value");

  // input back-pressure only when the result stage is stuck
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with result stage free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind iir_direct_form_filter_core iirdf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirdf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out),
  .saturated  (saturated)
);

`default_nettype wire
